### rtl/core/gn3o_pkg.sv
// Shared types and constants of the octave gradient noise unit.
// Holds opcodes, sequencer states, register indexes and datapath widths.
// No dependencies.
package gn3o_pkg;

   typedef enum logic [1:0] {
      OP_PERM_WR = 2'd0,
      OP_GRAD_WR = 2'd1,
      OP_EVAL    = 2'd2
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BASE,
      ST_SPLIT,
      ST_LOOK,
      ST_GRAD,
      ST_BLEND,
      ST_SCALE,
      ST_ACCUM,
      ST_FINISH
   } state_type;

   // Entries of each table. Cell and index wrapping take the low bits, so this
   // stays a power of two.
   localparam int TABLE_SIZE = 256;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_FREQ = 2'd0;
   localparam logic [1:0] REG_AMP  = 2'd1;
   localparam logic [1:0] REG_OCT  = 2'd2;

   localparam logic [15:0] FREQ_RESET = 16'd256;
   localparam logic [15:0] AMP_RESET  = 16'd256;
   localparam logic [3:0]  OCT_RESET  = 4'd1;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 37;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   // Corner dot products and blends, accumulator.
   localparam int VAL_W   = 36;
   localparam int ACC_W   = 56;

   // 3.0 in Q.16 for the s-curve factor (3 - 2t), and 1.0 in Q.16.
   localparam logic [MUL_A_W-1:0] SCURVE_THREE = 37'd196608;
   localparam logic signed [17:0] ONE_Q16      = 18'sh10000;

   // Last blend of the reduction tree; first blend steps that use sy and sz.
   localparam logic [2:0] LAST_BLEND  = 3'd6;
   localparam logic [2:0] FIRST_Y_BLD = 3'd4;
   localparam logic [2:0] FIRST_Z_BLD = 3'd6;
   localparam logic [3:0] CORNER_END  = 4'd8;

endpackage

### rtl/core/gradient_noise_3d_octaves_unit.sv
// Octave-summed 3D gradient noise unit: sequencer, shared multiplier, two tables.
// Depends on gn3o_pkg and gn3o_ram.
//
// A request beat with a write opcode loads one permutation or gradient entry and
// produces no response. An evaluate beat first scales the point, then for each of
// the N effective octaves splits the cell, runs the chained permutation lookups and
// s-curves, the eight gradient reads and dot products, the seven blends, and the
// weighting and summing; with N zero it goes straight to the result. The length of
// an evaluation is set by the single shared multiplier, which takes every product of
// the octave, and by the one read port of each table. The unit handles one
// evaluation at a time; it takes the next request beat while a finished response
// still waits in the output register. Tables have no reset and must be loaded
// before use. Configuration is to be written through the CSR port while the unit
// idles; the unit itself does not enforce this.
module gradient_noise_3d_octaves_unit #(
   parameter int MAX_OCTAVES   = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [7:0]         req_table_index,
   input  logic [7:0]         req_perm_value,
   input  logic signed [15:0] req_grad_x,
   input  logic signed [15:0] req_grad_y,
   input  logic signed [15:0] req_grad_z,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_noise_value,
   // configuration port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int TABLE_SIZE = gn3o_pkg::TABLE_SIZE;
   localparam int IW       = $clog2(TABLE_SIZE);
   localparam int OW       = $clog2(MAX_OCTAVES + 1);
   // Position carries FRACTION_BITS + 8 fraction bits after the Q8.8 frequency.
   localparam int SH       = FRACTION_BITS + 8;
   localparam int SH_BASE  = 38 - FRACTION_BITS;
   localparam int VW       = gn3o_pkg::VAL_W;
   localparam int AW       = gn3o_pkg::ACC_W;
   localparam logic signed [AW-1:0] SAT_HI = AW'(64'sd2147483647);
   localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

   function automatic logic [IW-1:0] perm_index(logic [7:0] v);
      return IW'({{IW{1'b0}}, v});
   endfunction

   // In-cell offset toward the near corner, or toward the far corner when far is set.
   function automatic logic signed [17:0] offset_of(logic [15:0] f, logic far);
      logic signed [17:0] near_v;
      near_v = {2'b00, f};
      return far ? near_v - gn3o_pkg::ONE_Q16 : near_v;
   endfunction

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   gn3o_pkg::state_type state_ff, state_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [3:0]  corner_ff, corner_in;
   logic [1:0]  ph_ff, ph_in;
   logic [2:0]  step_ff, step_in;
   logic [OW-1:0] k_ff, k_in;
   logic [OW-1:0] n_ff, n_in;

   logic [15:0] freq_ff, freq_in;
   logic [15:0] amp_ff, amp_in;
   logic [3:0]  oct_ff, oct_in;

   logic signed [31:0] coord_x_ff, coord_x_in;
   logic signed [31:0] coord_y_ff, coord_y_in;
   logic signed [31:0] coord_z_ff, coord_z_in;
   logic signed [47:0] base_x_ff, base_x_in;
   logic signed [47:0] base_y_ff, base_y_in;
   logic signed [47:0] base_z_ff, base_z_in;

   logic [IW-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [15:0]   fx_ff, fx_in, fy_ff, fy_in, fz_ff, fz_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in;
   logic [IW-1:0] b00_ff, b00_in, b10_ff, b10_in, b01_ff, b01_in, b11_ff, b11_in;
   logic [15:0]   sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic signed [15:0] gy_ff, gy_in, gz_ff, gz_in;

   logic signed [VW-1:0] dot_ff, dot_in;
   logic signed [VW-1:0] q_ff [8];
   logic signed [VW-1:0] q_in [8];
   logic signed [VW-1:0] a_ff, a_in;
   logic signed [AW-1:0] acc_ff, acc_in;

   logic signed [gn3o_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [gn3o_pkg::MUL_A_W-1:0] mul_a;
   logic signed [gn3o_pkg::MUL_B_W-1:0] mul_b;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_noise_ff, rsp_noise_in;

   // ------------------------------------------------------------------
   // Handshakes and table write ports
   // ------------------------------------------------------------------
   logic req_accept;
   logic cfg_we;
   logic perm_we, grad_we, index_ok;
   logic [IW-1:0] wr_addr;
   logic [IW-1:0] perm_rd_addr, grad_rd_addr;
   logic [7:0]    perm_rd_data;
   logic [47:0]   grad_rd_data;

   assign req_stall  = (state_ff != gn3o_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Writes land only while idle and read addresses are driven only while busy, so
   // no table read that the sequencer uses meets a write in the same cycle.
   assign index_ok = (32'(req_table_index) < TABLE_SIZE);
   assign wr_addr  = IW'({{IW{1'b0}}, req_table_index});
   assign perm_we  = req_accept && (req_opcode == gn3o_pkg::OP_PERM_WR) && index_ok;
   assign grad_we  = req_accept && (req_opcode == gn3o_pkg::OP_GRAD_WR) && index_ok;

   gn3o_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_perm_ram (
      .clock   (clock),
      .wr_en   (perm_we),
      .wr_addr (wr_addr),
      .wr_data (req_perm_value),
      .rd_addr (perm_rd_addr),
      .rd_data (perm_rd_data)
   );

   gn3o_ram #(.WIDTH(48), .DEPTH(TABLE_SIZE)) u_grad_ram (
      .clock   (clock),
      .wr_en   (grad_we),
      .wr_addr (wr_addr),
      .wr_data ({req_grad_x, req_grad_y, req_grad_z}),
      .rd_addr (grad_rd_addr),
      .rd_data (grad_rd_data)
   );

   always_comb begin
      unique case (csr_paddr[3:2])
         gn3o_pkg::REG_FREQ: csr_prdata = {16'd0, freq_ff};
         gn3o_pkg::REG_AMP:  csr_prdata = {16'd0, amp_ff};
         gn3o_pkg::REG_OCT:  csr_prdata = {28'd0, oct_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer and datapath
   // ------------------------------------------------------------------
   logic signed [63:0] pos_x, pos_y, pos_z;
   logic [2:0]  cur_c, prv_c;
   logic [IW-1:0] row_sel;
   logic [15:0] s_sel;
   logic [5:0]  sh_amt;
   logic signed [gn3o_pkg::PROD_W-1:0] contrib;

   assign pos_x  = $signed({{16{base_x_ff[47]}}, base_x_ff}) <<< k_ff;
   assign pos_y  = $signed({{16{base_y_ff[47]}}, base_y_ff}) <<< k_ff;
   assign pos_z  = $signed({{16{base_z_ff[47]}}, base_z_ff}) <<< k_ff;
   assign cur_c  = corner_ff[2:0];
   assign prv_c  = 3'(corner_ff - 4'd1);
   assign sh_amt = 6'(SH_BASE) + 6'(k_ff);
   assign contrib = prod_ff >>> sh_amt;

   always_comb begin
      unique case (cur_c[1:0])
         2'd0: row_sel = b00_ff;
         2'd1: row_sel = b10_ff;
         2'd2: row_sel = b01_ff;
         default: row_sel = b11_ff;
      endcase
      if (step_ff < gn3o_pkg::FIRST_Y_BLD) begin
         s_sel = sx_ff;
      end else if (step_ff < gn3o_pkg::FIRST_Z_BLD) begin
         s_sel = sy_ff;
      end else begin
         s_sel = sz_ff;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      corner_in  = corner_ff;
      ph_in      = ph_ff;
      step_in    = step_ff;
      k_in       = k_ff;
      n_in       = n_ff;
      freq_in    = freq_ff;
      amp_in     = amp_ff;
      oct_in     = oct_ff;
      coord_x_in = coord_x_ff;
      coord_y_in = coord_y_ff;
      coord_z_in = coord_z_ff;
      base_x_in  = base_x_ff;
      base_y_in  = base_y_ff;
      base_z_in  = base_z_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      fx_in = fx_ff; fy_in = fy_ff; fz_in = fz_ff;
      i_in = i_ff; j_in = j_ff;
      b00_in = b00_ff; b10_in = b10_ff; b01_in = b01_ff; b11_in = b11_ff;
      sx_in = sx_ff; sy_in = sy_ff; sz_in = sz_ff;
      gy_in = gy_ff; gz_in = gz_ff;
      dot_in = dot_ff;
      for (int e = 0; e < 8; e++) begin
         q_in[e] = q_ff[e];
      end
      a_in         = a_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_noise_in = rsp_noise_ff;
      mul_a        = '0;
      mul_b        = '0;
      perm_rd_addr = '0;
      grad_rd_addr = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cfg_we) begin
         unique case (csr_paddr[3:2])
            gn3o_pkg::REG_FREQ: freq_in = csr_pwdata[15:0];
            gn3o_pkg::REG_AMP:  amp_in  = csr_pwdata[15:0];
            gn3o_pkg::REG_OCT:  oct_in  = csr_pwdata[3:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         gn3o_pkg::ST_IDLE: begin
            if (req_accept && (req_opcode == gn3o_pkg::OP_EVAL)) begin
               coord_x_in = req_coord_x;
               coord_y_in = req_coord_y;
               coord_z_in = req_coord_z;
               acc_in     = '0;
               k_in       = '0;
               cnt_in     = '0;
               if (32'(oct_ff) > MAX_OCTAVES) begin
                  n_in = OW'(MAX_OCTAVES);
               end else begin
                  n_in = OW'(oct_ff);
               end
               state_in = (oct_ff == 4'd0) ? gn3o_pkg::ST_FINISH : gn3o_pkg::ST_BASE;
            end
         end

         gn3o_pkg::ST_BASE: begin
            mul_b = {2'b00, freq_ff};
            unique case (cnt_ff)
               3'd0: mul_a = {{5{coord_x_ff[31]}}, coord_x_ff};
               3'd1: begin
                  base_x_in = prod_ff[47:0];
                  mul_a = {{5{coord_y_ff[31]}}, coord_y_ff};
               end
               3'd2: begin
                  base_y_in = prod_ff[47:0];
                  mul_a = {{5{coord_z_ff[31]}}, coord_z_ff};
               end
               default: base_z_in = prod_ff[47:0];
            endcase
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) begin
               state_in = gn3o_pkg::ST_SPLIT;
            end
         end

         gn3o_pkg::ST_SPLIT: begin
            // Two's complement bits give floor and the wrap at once.
            cx_in = pos_x[SH+IW-1:SH];
            cy_in = pos_y[SH+IW-1:SH];
            cz_in = pos_z[SH+IW-1:SH];
            fx_in = pos_x[SH-1:SH-16];
            fy_in = pos_y[SH-1:SH-16];
            fz_in = pos_z[SH-1:SH-16];
            cnt_in   = '0;
            state_in = gn3o_pkg::ST_LOOK;
         end

         gn3o_pkg::ST_LOOK: begin
            // Chained permutation reads run alongside the three s-curves.
            unique case (cnt_ff)
               3'd0: begin
                  perm_rd_addr = cx_ff;
                  mul_a = {21'd0, fx_ff};
                  mul_b = {2'b00, fx_ff};
               end
               3'd1: begin
                  i_in = perm_index(perm_rd_data);
                  perm_rd_addr = cx_ff + IW'(1);
                  mul_a = gn3o_pkg::SCURVE_THREE - {20'd0, fx_ff, 1'b0};
                  mul_b = {2'b00, prod_ff[31:16]};
               end
               3'd2: begin
                  j_in = perm_index(perm_rd_data);
                  perm_rd_addr = i_ff + cy_ff;
                  sx_in = prod_ff[31:16];
                  mul_a = {21'd0, fy_ff};
                  mul_b = {2'b00, fy_ff};
               end
               3'd3: begin
                  b00_in = perm_index(perm_rd_data);
                  perm_rd_addr = j_ff + cy_ff;
                  mul_a = gn3o_pkg::SCURVE_THREE - {20'd0, fy_ff, 1'b0};
                  mul_b = {2'b00, prod_ff[31:16]};
               end
               3'd4: begin
                  b10_in = perm_index(perm_rd_data);
                  perm_rd_addr = i_ff + cy_ff + IW'(1);
                  sy_in = prod_ff[31:16];
                  mul_a = {21'd0, fz_ff};
                  mul_b = {2'b00, fz_ff};
               end
               3'd5: begin
                  b01_in = perm_index(perm_rd_data);
                  perm_rd_addr = j_ff + cy_ff + IW'(1);
                  mul_a = gn3o_pkg::SCURVE_THREE - {20'd0, fz_ff, 1'b0};
                  mul_b = {2'b00, prod_ff[31:16]};
               end
               default: begin
                  b11_in = perm_index(perm_rd_data);
                  sz_in  = prod_ff[31:16];
               end
            endcase
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd6) begin
               corner_in = '0;
               ph_in     = '0;
               state_in  = gn3o_pkg::ST_GRAD;
            end
         end

         gn3o_pkg::ST_GRAD: begin
            // Per corner: read, then x, y, z products. The z
            // product of one corner overlaps the read of the next.
            unique case (ph_ff)
               2'd0: begin
                  grad_rd_addr = row_sel + (cur_c[2] ? cz_ff + IW'(1) : cz_ff);
                  mul_a = {{21{gz_ff[15]}}, gz_ff};
                  mul_b = offset_of(fz_ff, prv_c[2]);
                  if (corner_ff != 4'd0) begin
                     dot_in = dot_ff + VW'(prod_ff);
                  end
                  ph_in = 2'd1;
               end
               2'd1: begin
                  gy_in = grad_rd_data[31:16];
                  gz_in = grad_rd_data[15:0];
                  mul_a = {{21{grad_rd_data[47]}}, grad_rd_data[47:32]};
                  mul_b = offset_of(fx_ff, cur_c[0]);
                  if (corner_ff != 4'd0) begin
                     q_in[prv_c] = dot_ff + VW'(prod_ff);
                  end
                  if (corner_ff == gn3o_pkg::CORNER_END) begin
                     step_in  = '0;
                     ph_in    = '0;
                     state_in = gn3o_pkg::ST_BLEND;
                  end else begin
                     ph_in = 2'd2;
                  end
               end
               default: begin
                  mul_a = {{21{gy_ff[15]}}, gy_ff};
                  mul_b = offset_of(fy_ff, cur_c[1]);
                  dot_in    = VW'(prod_ff);
                  ph_in     = 2'd0;
                  corner_in = corner_ff + 4'd1;
               end
            endcase
         end

         gn3o_pkg::ST_BLEND: begin
            // The corner values form a queue: each blend takes the two at the
            // head and appends its result, so x, then y, then z pairs reduce.
            if (ph_ff == 2'd0) begin
               mul_a = {q_ff[1][VW-1], q_ff[1]} - {q_ff[0][VW-1], q_ff[0]};
               mul_b = {2'b00, s_sel};
               a_in  = q_ff[0];
               for (int e = 0; e < 6; e++) begin
                  q_in[e] = q_ff[e+2];
               end
               ph_in = 2'd1;
            end else begin
               q_in[3'(gn3o_pkg::LAST_BLEND - step_ff)] = a_ff + VW'(prod_ff >>> 16);
               ph_in = 2'd0;
               if (step_ff == gn3o_pkg::LAST_BLEND) begin
                  state_in = gn3o_pkg::ST_SCALE;
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end
         end

         gn3o_pkg::ST_SCALE: begin
            mul_a    = {q_ff[0][VW-1], q_ff[0]};
            mul_b    = {2'b00, amp_ff};
            state_in = gn3o_pkg::ST_ACCUM;
         end

         gn3o_pkg::ST_ACCUM: begin
            acc_in = acc_ff + AW'(contrib);
            if (k_ff == n_ff - OW'(1)) begin
               state_in = gn3o_pkg::ST_FINISH;
            end else begin
               k_in     = k_ff + OW'(1);
               state_in = gn3o_pkg::ST_SPLIT;
            end
         end

         default: begin
            // Finish: wait until the output register is free, then saturate.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (acc_ff > SAT_HI) begin
                  rsp_noise_in = 32'sh7fffffff;
               end else if (acc_ff < SAT_LO) begin
                  rsp_noise_in = 32'sh80000000;
               end else begin
                  rsp_noise_in = acc_ff[31:0];
               end
               state_in = gn3o_pkg::ST_IDLE;
            end
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gn3o_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         freq_ff      <= gn3o_pkg::FREQ_RESET;
         amp_ff       <= gn3o_pkg::AMP_RESET;
         oct_ff       <= gn3o_pkg::OCT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         freq_ff      <= freq_in;
         amp_ff       <= amp_in;
         oct_ff       <= oct_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      corner_ff  <= corner_in;
      ph_ff      <= ph_in;
      step_ff    <= step_in;
      k_ff       <= k_in;
      n_ff       <= n_in;
      coord_x_ff <= coord_x_in;
      coord_y_ff <= coord_y_in;
      coord_z_ff <= coord_z_in;
      base_x_ff  <= base_x_in;
      base_y_ff  <= base_y_in;
      base_z_ff  <= base_z_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      fx_ff <= fx_in; fy_ff <= fy_in; fz_ff <= fz_in;
      i_ff <= i_in; j_ff <= j_in;
      b00_ff <= b00_in; b10_ff <= b10_in; b01_ff <= b01_in; b11_ff <= b11_in;
      sx_ff <= sx_in; sy_ff <= sy_in; sz_ff <= sz_in;
      gy_ff <= gy_in; gz_ff <= gz_in;
      dot_ff <= dot_in;
      for (int e = 0; e < 8; e++) begin
         q_ff[e] <= q_in[e];
      end
      a_ff         <= a_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      rsp_noise_ff <= rsp_noise_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_eval_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_opcode == gn3o_pkg::OP_EVAL)) |=> (state_ff != gn3o_pkg::ST_IDLE))
      else $error("evaluate beat did not start the sequencer");

   a_no_table_write_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != gn3o_pkg::ST_IDLE) |-> (!perm_we && !grad_we))
      else $error("table written during an evaluation");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == gn3o_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall))
      |=> (rsp_valid_ff && (state_ff == gn3o_pkg::ST_IDLE)))
      else $error("finished result not loaded into the output register");

   a_corner_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gn3o_pkg::ST_GRAD) |-> (corner_ff <= gn3o_pkg::CORNER_END))
      else $error("corner counter ran past the last corner");

   a_octave_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gn3o_pkg::ST_SPLIT) |-> (k_ff < n_ff))
      else $error("octave index beyond the octave count");

endmodule

### rtl/core/gn3o_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gn3o_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### test/tb_gradient_noise_3d_octaves_unit.sv
// Self-checking testbench of the octave gradient noise unit.
// Depends on gn3o_pkg and the RTL of gradient_noise_3d_octaves_unit.
// Drives random and directed request beats and checks each response against a local predictor.
module tb_gradient_noise_3d_octaves_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // Opcode three carries no operation; the unit must drop it without a response.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int LIMIT_CYCLES = 3000000;
   // Drain waits comfortably longer than the longest evaluation.
   localparam int DRAIN_CYCLES = 600;

   // Idling modes of one phase.
   localparam int IDLE_NONE = 0;
   localparam int IDLE_SEND = 1;
   localparam int IDLE_RECV = 2;
   localparam int IDLE_BOTH = 3;

   typedef struct {
      logic [1:0]         opcode;
      logic [7:0]         table_index;
      logic [7:0]         perm_value;
      logic signed [15:0] grad_x;
      logic signed [15:0] grad_y;
      logic signed [15:0] grad_z;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
   } noise_req_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode = '0;
   logic [7:0]         req_table_index = '0;
   logic [7:0]         req_perm_value = '0;
   logic signed [15:0] req_grad_x = '0;
   logic signed [15:0] req_grad_y = '0;
   logic signed [15:0] req_grad_z = '0;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic signed [31:0] req_coord_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_noise_value;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   gradient_noise_3d_octaves_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_table_index(req_table_index), .req_perm_value(req_perm_value),
      .req_grad_x(req_grad_x), .req_grad_y(req_grad_y), .req_grad_z(req_grad_z),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_noise_value(rsp_noise_value),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   // Shadow copies of the tables and the configuration registers.
   logic [7:0]         perm_shadow [256];
   logic signed [15:0] grad_shadow [256][3];
   longint             freq_shadow = 256;
   longint             amp_shadow  = 256;
   int                 oct_shadow  = 1;

   noise_req_type      pending_beats [$];
   logic signed [31:0] noise_expected [$];
   int                 idle_mode = IDLE_NONE;
   int                 error_count = 0;
   longint             cycle_count = 0;

   // ---------------------------------------------------------------
   // Predictor. Positions carry 24 fraction bits; the cell is the
   // floor of the position modulo 256 and the offset is Q0.16.
   // ---------------------------------------------------------------
   function automatic longint s_curve(longint f);
      longint t2;
      t2 = (f * f) >>> 16;
      return (t2 * (196608 - 2 * f)) >>> 16;
   endfunction

   function automatic longint lerp_q16(longint s, longint a, longint b);
      return a + (((b - a) * s) >>> 16);
   endfunction

   function automatic longint corner_dot(int row, int cz, longint rx, longint ry, longint rz);
      int g;
      g = (row + cz) & 255;
      return rx * longint'(grad_shadow[g][0]) + ry * longint'(grad_shadow[g][1])
           + rz * longint'(grad_shadow[g][2]);
   endfunction

   function automatic longint octave_noise(longint px, longint py, longint pz);
      int     cx, cy, cz, cx1, cy1, cz1, pi, pj, b00, b10, b01, b11;
      longint fx, fy, fz, sx, sy, sz, a, b, c, d;
      cx = int'((px >>> 24) & 255);
      cy = int'((py >>> 24) & 255);
      cz = int'((pz >>> 24) & 255);
      fx = (px >>> 8) & 65535;
      fy = (py >>> 8) & 65535;
      fz = (pz >>> 8) & 65535;
      cx1 = (cx + 1) & 255;
      cy1 = (cy + 1) & 255;
      cz1 = (cz + 1) & 255;
      pi  = int'(perm_shadow[cx]);
      pj  = int'(perm_shadow[cx1]);
      b00 = int'(perm_shadow[(pi + cy) & 255]);
      b10 = int'(perm_shadow[(pj + cy) & 255]);
      b01 = int'(perm_shadow[(pi + cy1) & 255]);
      b11 = int'(perm_shadow[(pj + cy1) & 255]);
      sx = s_curve(fx);
      sy = s_curve(fy);
      sz = s_curve(fz);
      a = lerp_q16(sx, corner_dot(b00, cz, fx, fy, fz),
                   corner_dot(b10, cz, fx - 65536, fy, fz));
      b = lerp_q16(sx, corner_dot(b01, cz, fx, fy - 65536, fz),
                   corner_dot(b11, cz, fx - 65536, fy - 65536, fz));
      c = lerp_q16(sy, a, b);
      a = lerp_q16(sx, corner_dot(b00, cz1, fx, fy, fz - 65536),
                   corner_dot(b10, cz1, fx - 65536, fy, fz - 65536));
      b = lerp_q16(sx, corner_dot(b01, cz1, fx, fy - 65536, fz - 65536),
                   corner_dot(b11, cz1, fx - 65536, fy - 65536, fz - 65536));
      d = lerp_q16(sy, a, b);
      return lerp_q16(sz, c, d);
   endfunction

   // Applies one accepted beat to the shadow state and queues the response it causes.
   function automatic void apply_noise_beat(noise_req_type r);
      longint bx, by, bz, sum, v;
      int     n;
      case (r.opcode)
         gn3o_pkg::OP_PERM_WR: perm_shadow[r.table_index] = r.perm_value;
         gn3o_pkg::OP_GRAD_WR: begin
            grad_shadow[r.table_index][0] = r.grad_x;
            grad_shadow[r.table_index][1] = r.grad_y;
            grad_shadow[r.table_index][2] = r.grad_z;
         end
         gn3o_pkg::OP_EVAL: begin
            bx = longint'(r.coord_x) * freq_shadow;
            by = longint'(r.coord_y) * freq_shadow;
            bz = longint'(r.coord_z) * freq_shadow;
            n = (oct_shadow > 8) ? 8 : oct_shadow;
            sum = 0;
            for (int k = 0; k < n; k++) begin
               v = octave_noise(bx <<< k, by <<< k, bz <<< k);
               sum += (v * amp_shadow) >>> (22 + k);
            end
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            noise_expected.push_back(sum[31:0]);
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Request driver: presents the next pending beat once the current
   // one is taken, idling at random according to the phase.
   // ---------------------------------------------------------------
   noise_req_type shown;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            apply_noise_beat(shown);
         end
         if (pending_beats.size() > 0 &&
             !((idle_mode == IDLE_SEND && $urandom_range(99) < 75) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 7))) begin
            shown = pending_beats.pop_front();
            req_valid       <= 1'b1;
            req_opcode      <= shown.opcode;
            req_table_index <= shown.table_index;
            req_perm_value  <= shown.perm_value;
            req_grad_x      <= shown.grad_x;
            req_grad_y      <= shown.grad_y;
            req_grad_z      <= shown.grad_z;
            req_coord_x     <= shown.coord_x;
            req_coord_y     <= shown.coord_y;
            req_coord_z     <= shown.coord_z;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Response monitor and stall generator. Every accepted beat must
   // match the oldest prediction.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (idle_mode == IDLE_RECV && $urandom_range(99) < 75) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(99) < 7);
         if (rsp_valid && !rsp_stall) begin
            if (noise_expected.size() == 0) begin
               $display("%0t: unexpected response noise_value=%0d", $time, rsp_noise_value);
               error_count++;
            end else begin
               if (rsp_noise_value !== noise_expected[0]) begin
                  $display("%0t: noise_value mismatch expected=%0d actual=%0d",
                           $time, noise_expected[0], rsp_noise_value);
                  error_count++;
               end
               void'(noise_expected.pop_front());
            end
         end
      end
   end

   // Watchdog for a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------
   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         gn3o_pkg::REG_FREQ: freq_shadow = longint'(value[15:0]);
         gn3o_pkg::REG_AMP:  amp_shadow  = longint'(value[15:0]);
         gn3o_pkg::REG_OCT:  oct_shadow  = int'(value[3:0]);
         default: ;
      endcase
   endtask

   function automatic noise_req_type blank_beat(logic [1:0] op);
      noise_req_type r;
      r.opcode      = op;
      r.table_index = 8'($urandom);
      r.perm_value  = 8'($urandom);
      r.grad_x      = 16'($urandom);
      r.grad_y      = 16'($urandom);
      r.grad_z      = 16'($urandom);
      r.coord_x     = $urandom;
      r.coord_y     = $urandom;
      r.coord_z     = $urandom;
      return r;
   endfunction

   // Mostly Q1.14 unit range, sometimes any 16-bit value.
   function automatic logic signed [15:0] pick_grad();
      if ($urandom_range(9) == 0) return 16'($urandom);
      return 16'($signed($urandom_range(32768)) - 32'sd16384);
   endfunction

   // Small coordinates near the origin and cell edges, plus full-range values.
   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(4))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2 * 65536 * 16)) - 32'sd1048576);
         2: return 32'(($signed($urandom_range(63)) - 32) * 65536 + $urandom_range(3) - 2);
         3: return $urandom_range(1) ? 32'(32'sh7fffffff - $urandom_range(70000))
                                     : 32'(32'sh80000000 + $urandom_range(70000));
         default: return 32'($signed($urandom_range(600000)) - 32'sd300000);
      endcase
   endfunction

   function automatic noise_req_type eval_beat(logic signed [31:0] x, logic signed [31:0] y,
                                               logic signed [31:0] z);
      noise_req_type r;
      r = blank_beat(gn3o_pkg::OP_EVAL);
      r.coord_x = x;
      r.coord_y = y;
      r.coord_z = z;
      return r;
   endfunction

   function automatic noise_req_type grad_beat(logic [7:0] idx, logic signed [15:0] gx,
                                               logic signed [15:0] gy, logic signed [15:0] gz);
      noise_req_type r;
      r = blank_beat(gn3o_pkg::OP_GRAD_WR);
      r.table_index = idx;
      r.grad_x = gx;
      r.grad_y = gy;
      r.grad_z = gz;
      return r;
   endfunction

   function automatic noise_req_type random_beat();
      noise_req_type r;
      int            pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         r = eval_beat(pick_coord(), pick_coord(), pick_coord());
      end else if (pick < 75) begin
         r = grad_beat(8'($urandom), pick_grad(), pick_grad(), pick_grad());
      end else if (pick < 95) begin
         r = blank_beat(gn3o_pkg::OP_PERM_WR);
      end else begin
         r = blank_beat(OP_UNUSED);
      end
      return r;
   endfunction

   // Waits until every queued beat was taken and every response came back,
   // then lets a full evaluation time pass before the unit is touched.
   task automatic drain();
      while (pending_beats.size() > 0 || req_valid || noise_expected.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Test sequence: fill both tables, a directed set at reset
   // configuration, then random phases under several settings.
   // ---------------------------------------------------------------
   initial begin
      noise_req_type r;
      int            freq_set [6];
      int            amp_set  [6];
      int            oct_set  [6];

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Every entry is written before the first evaluation reads any.
      for (int i = 0; i < 256; i++) begin
         r = blank_beat(gn3o_pkg::OP_PERM_WR);
         r.table_index = 8'(i);
         pending_beats.push_back(r);
         pending_beats.push_back(grad_beat(8'(i), pick_grad(), pick_grad(), pick_grad()));
      end

      // Directed beats: table value extremes, gradient extremes and
      // out-of-range components, coordinate extremes and the unused opcode.
      r = blank_beat(gn3o_pkg::OP_PERM_WR);
      r.table_index = 8'd0;
      r.perm_value  = 8'd255;
      pending_beats.push_back(r);
      r.table_index = 8'd255;
      r.perm_value  = 8'd0;
      pending_beats.push_back(r);
      pending_beats.push_back(grad_beat(8'd0, 16'sd16384, -16'sd16384, 16'sd0));
      pending_beats.push_back(grad_beat(8'd255, -16'sd32768, 16'sd32767, 16'sd16384));
      pending_beats.push_back(grad_beat(8'd1, 16'sd32767, -16'sd32768, -16'sd16384));
      pending_beats.push_back(eval_beat(0, 0, 0));
      pending_beats.push_back(eval_beat(-1, -1, -1));
      pending_beats.push_back(eval_beat(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
      pending_beats.push_back(eval_beat(32'sh80000000, 32'sh80000000, 32'sh80000000));
      pending_beats.push_back(eval_beat(32'sh10000, -32'sh10000, 32'sh8000));
      pending_beats.push_back(eval_beat(32'sh7fffffff, 32'sh80000000, 0));
      pending_beats.push_back(eval_beat(32'sh0000ffff, 32'sh0001ffff, 32'shffff0001));
      pending_beats.push_back(blank_beat(OP_UNUSED));
      r = blank_beat(OP_UNUSED);
      r.table_index = 8'hff;
      pending_beats.push_back(r);
      pending_beats.push_back(eval_beat(32'sh00018000, 32'sh00028000, 32'sh00038000));
      drain();

      // Register settings per phase, extremes included; zero octaves gives zero.
      freq_set = '{65535, 0,    $urandom_range(65535), 512,   $urandom_range(2048), 1};
      amp_set  = '{65535, 1000, $urandom_range(65535), 65535, $urandom_range(65535), 0};
      oct_set  = '{8,     15,   0,                     3,     2,                     1};

      for (int p = 0; p < 6; p++) begin
         csr_write(gn3o_pkg::REG_FREQ, freq_set[p]);
         csr_write(gn3o_pkg::REG_AMP, amp_set[p]);
         csr_write(gn3o_pkg::REG_OCT, oct_set[p]);
         idle_mode = p % 4;
         for (int n = 0; n < 220; n++)
            pending_beats.push_back(random_beat());
         drain();
      end

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/gn3o_pkg.sv
rtl/core/gn3o_ram.sv
rtl/core/gradient_noise_3d_octaves_unit.sv
test/tb_gradient_noise_3d_octaves_unit.sv
